// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and step functions for the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int NUM_W     = IN_W + 2;          // sums/differences of entries
  localparam int A_W       = IN_W + 3;          // root argument, signed
  localparam int RAD_W     = 32;                // radicand a << FRAC_BITS
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int Q_W       = IN_W - 1;          // quotient bits below saturation
  localparam int SQ_PER    = 2;                 // root iterations per stage
  localparam int SQ_ST     = ROOT_W / SQ_PER;
  localparam int DV_PER    = 2;                 // quotient bits per stage
  localparam int DV_ST     = (Q_W + DV_PER - 1) / DV_PER;

  localparam logic signed [IN_W-1:0] Q_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] Q_MIN = {1'b1, {(IN_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

  // square root pipeline payload
  typedef struct packed {
    case_t                     which;
    logic [3:0][NUM_W-1:0]     num;
    logic [RAD_W-1:0]          rad;
    logic [REM_W-1:0]          rem;
    logic [ROOT_W-1:0]         root;
  } sq_t;

  // divider pipeline payload, four lanes (the chosen lane is unused)
  typedef struct packed {
    case_t                     which;
    logic [ROOT_W-1:0]         root;
    logic [DEN_W-1:0]          den;
    logic [3:0]                neg;
    logic [3:0]                ovf;
    logic [3:0][RAD_W-1:0]     rem;
    logic [3:0][Q_W-1:0]       q;
  } dv_t;

  // one restoring square root iteration, two radicand bits
  function automatic sq_t sq_iter(sq_t s);
    sq_t              o;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    o     = s;
    rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division step on all lanes for quotient bit b
  function automatic dv_t dv_iter(dv_t d, int b);
    dv_t              o;
    logic [RAD_W-1:0] sub;
    o   = d;
    sub = RAD_W'(d.den) << b;
    for (int l = 0; l < 4; l++) begin
      if (d.rem[l] >= sub) begin
        o.rem[l]    = d.rem[l] - sub;
        o.q[l][b]   = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// Pipeline: 19 register stages from the taken input beat to out_valid.
// Throughput: one matrix per cycle while out_stall is low; set by the 8-stage root pipeline
// (2 bits per stage) and the 8-stage divider (15 quotient bits, 2 per stage).
// Stalls collapse bubbles stage by stage; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd conversion of a Q1.14 rotation matrix to a saturated quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_m00,
  input  logic signed [IN_W-1:0] in_m01,
  input  logic signed [IN_W-1:0] in_m02,
  input  logic signed [IN_W-1:0] in_m10,
  input  logic signed [IN_W-1:0] in_m11,
  input  logic signed [IN_W-1:0] in_m12,
  input  logic signed [IN_W-1:0] in_m20,
  input  logic signed [IN_W-1:0] in_m21,
  input  logic signed [IN_W-1:0] in_m22,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [IN_W-1:0] out_quat_w,
  output logic signed [IN_W-1:0] out_quat_x,
  output logic signed [IN_W-1:0] out_quat_y,
  output logic signed [IN_W-1:0] out_quat_z,
  output logic [1:0]             out_case_taken
);

  sq_t  sq_r   [0:SQ_ST];
  logic sq_vld_r [0:SQ_ST];
  logic sq_rdy [0:SQ_ST];
  dv_t  dv_r   [0:DV_ST];
  logic dv_vld_r [0:DV_ST];
  logic dv_rdy [0:DV_ST];

  logic                   out_valid_r;
  logic                   out_rdy;
  logic signed [IN_W-1:0] qw_r, qx_r, qy_r, qz_r;
  case_t                  case_r;

  // backward ready chain: a stage loads when empty or its successor loads
  always_comb begin
    out_rdy = !out_valid_r || !out_stall;
    dv_rdy[DV_ST] = !dv_vld_r[DV_ST] || out_rdy;
    for (int i = DV_ST - 1; i >= 0; i--) begin
      dv_rdy[i] = !dv_vld_r[i] || dv_rdy[i+1];
    end
    sq_rdy[SQ_ST] = !sq_vld_r[SQ_ST] || dv_rdy[0];
    for (int i = SQ_ST - 1; i >= 0; i--) begin
      sq_rdy[i] = !sq_vld_r[i] || sq_rdy[i+1];
    end
  end

  assign in_stall = !sq_rdy[0];

  // front stage: branch choice, root argument, numerators
  logic signed [NUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [NUM_W-1:0] trace;
  logic signed [A_W-1:0]   a_arg;
  logic signed [A_W-1:0]   one_a;
  case_t                   which_c;
  sq_t                     front;

  always_comb begin
    e00 = NUM_W'(in_m00); e01 = NUM_W'(in_m01); e02 = NUM_W'(in_m02);
    e10 = NUM_W'(in_m10); e11 = NUM_W'(in_m11); e12 = NUM_W'(in_m12);
    e20 = NUM_W'(in_m20); e21 = NUM_W'(in_m21); e22 = NUM_W'(in_m22);
    one_a = A_W'(1) <<< FRAC_BITS;
    trace = e00 + e11 + e22;
    priority if (trace > 0)  which_c = CASE_TRACE;
    else if (e11 > e00)      which_c = (e22 > e11) ? CASE_Z : CASE_Y;
    else                     which_c = (e22 > e00) ? CASE_Z : CASE_X;

    front       = '0;
    front.which = which_c;
    unique case (which_c)
      CASE_TRACE: begin
        a_arg        = one_a + A_W'(trace);
        front.num[1] = e21 - e12;
        front.num[2] = e02 - e20;
        front.num[3] = e10 - e01;
      end
      CASE_X: begin
        a_arg        = A_W'(e00) - A_W'(e11) - A_W'(e22) + one_a;
        front.num[0] = e21 - e12;
        front.num[2] = e01 + e10;
        front.num[3] = e02 + e20;
      end
      CASE_Y: begin
        a_arg        = A_W'(e11) - A_W'(e22) - A_W'(e00) + one_a;
        front.num[0] = e02 - e20;
        front.num[1] = e10 + e01;
        front.num[3] = e12 + e21;
      end
      default: begin
        a_arg        = A_W'(e22) - A_W'(e00) - A_W'(e11) + one_a;
        front.num[0] = e10 - e01;
        front.num[1] = e20 + e02;
        front.num[2] = e21 + e12;
      end
    endcase
    // negative root argument clamps to zero
    front.rad = (a_arg > 0) ? (RAD_W'(a_arg[A_W-2:0]) << FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (sq_rdy[0]) begin
      sq_vld_r[0] <= in_valid;
    end
    if (sq_rdy[0]) sq_r[0] <= front;
  end

  // square root stages
  for (genvar k = 1; k <= SQ_ST; k++) begin : g_sq
    sq_t nxt;
    always_comb begin
      nxt = sq_r[k-1];
      for (int j = 0; j < SQ_PER; j++) nxt = sq_iter(nxt);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (sq_rdy[k]) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
      if (sq_rdy[k]) sq_r[k] <= nxt;
    end
  end

  // divider setup: divisor, signs, magnitudes, saturation flags
  dv_t pre;
  always_comb begin
    logic signed [NUM_W-1:0] n;
    logic [NUM_W-1:0]        mag;
    pre       = '0;
    pre.which = sq_r[SQ_ST].which;
    pre.root  = sq_r[SQ_ST].root;
    pre.den   = {sq_r[SQ_ST].root, 1'b0};
    for (int l = 0; l < 4; l++) begin
      n          = sq_r[SQ_ST].num[l];
      mag        = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
      pre.neg[l] = n[NUM_W-1];
      pre.rem[l] = RAD_W'(mag) << FRAC_BITS;
      if (pre.den == '0) pre.ovf[l] = (n != '0);
      else pre.ovf[l] = ({1'b0, pre.rem[l]} >= ((RAD_W+1)'(pre.den) << Q_W));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (dv_rdy[0]) begin
      dv_vld_r[0] <= sq_vld_r[SQ_ST];
    end
    if (dv_rdy[0]) dv_r[0] <= pre;
  end

  // divider stages, high quotient bits first
  for (genvar k = 1; k <= DV_ST; k++) begin : g_dv
    dv_t nxt;
    always_comb begin
      nxt = dv_r[k-1];
      for (int j = 0; j < DV_PER; j++) begin
        if (Q_W - 1 - (k-1)*DV_PER - j >= 0)
          nxt = dv_iter(nxt, Q_W - 1 - (k-1)*DV_PER - j);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (dv_rdy[k]) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      if (dv_rdy[k]) dv_r[k] <= nxt;
    end
  end

  // result assembly with saturation
  logic signed [IN_W-1:0] lane [0:3];
  always_comb begin
    logic signed [IN_W-1:0] qv;
    for (int l = 0; l < 4; l++) begin
      qv = IN_W'(dv_r[DV_ST].q[l]);
      if (l == int'(dv_r[DV_ST].which)) lane[l] = IN_W'(dv_r[DV_ST].root >> 1);
      else if (dv_r[DV_ST].ovf[l])      lane[l] = dv_r[DV_ST].neg[l] ? Q_MIN : Q_MAX;
      else                              lane[l] = dv_r[DV_ST].neg[l] ? -qv : qv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_vld_r[DV_ST];
    end
    if (out_rdy) begin
      qw_r   <= lane[0];
      qx_r   <= lane[1];
      qy_r   <= lane[2];
      qz_r   <= lane[3];
      case_r <= dv_r[DV_ST].which;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_w     = qw_r;
  assign out_quat_x     = qx_r;
  assign out_quat_y     = qy_r;
  assign out_quat_z     = qz_r;
  assign out_case_taken = case_r;

  // checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
  a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && case_r == CASE_TRACE |-> !qw_r[IN_W-1])
    else $error("negative w in trace branch");
  a_axis_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && case_r == CASE_X |-> !qx_r[IN_W-1])
    else $error("negative chosen component");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> sq_vld_r[0] && out_valid_r && out_stall)
    else $error("input stalled with room in pipeline");

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// Streams matrices through the Shepperd conversion pipeline with random gaps
// and output stalls, predicts each quaternion in fixed point and compares
// every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  localparam int N_RANDOM  = 1450;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 40;

  typedef logic signed [IN_W-1:0] q_t;

  typedef struct {
    q_t m [9];
  } matrix_t;

  typedef struct {
    q_t    w, x, y, z;
    case_t which;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  q_t   in_m00 = '0, in_m01 = '0, in_m02 = '0;
  q_t   in_m10 = '0, in_m11 = '0, in_m12 = '0;
  q_t   in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  q_t   out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [1:0] out_case_taken;

  matrix_t pending_mats [$];
  quat_t   expected_quats [$];
  int      n_errors = 0;
  int      idle_cycles = 0;
  bit      hold_input = 1'b0;
  bit      stim_done = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;

  rotation_matrix_to_quaternion_top dut (.*);

  always #2 clk = ~clk;

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // floor(sqrt(a)) at FRAC_BITS, negative argument clamps to zero
  function automatic longint root_fx(longint a);
    if (a <= 0) return 0;
    return longint'(int_sqrt(longint'(unsigned'(a)) << FRAC_BITS));
  endfunction

  // (num << FRAC_BITS) / den toward zero, rails on a zero divisor
  function automatic q_t ratio_fx(longint num, longint den);
    if (den <= 0) begin
      if (num > 0) return Q_MAX;
      if (num < 0) return Q_MIN;
      return '0;
    end
    return q_t'(clip16((num * (longint'(1) << FRAC_BITS)) / den));
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mt);
    quat_t  q;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, tr, r, den;
    a00 = mt.m[0]; a01 = mt.m[1]; a02 = mt.m[2];
    a10 = mt.m[3]; a11 = mt.m[4]; a12 = mt.m[5];
    a20 = mt.m[6]; a21 = mt.m[7]; a22 = mt.m[8];
    one = longint'(1) << FRAC_BITS;
    tr  = a00 + a11 + a22;
    if (tr > 0) q.which = CASE_TRACE;
    else if (a11 > a00) q.which = (a22 > a11) ? CASE_Z : CASE_Y;
    else q.which = (a22 > a00) ? CASE_Z : CASE_X;
    case (q.which)
      CASE_TRACE: begin
        r = root_fx(one + tr); den = 2 * r;
        q.w = q_t'(clip16(r >>> 1));
        q.x = ratio_fx(a21 - a12, den);
        q.y = ratio_fx(a02 - a20, den);
        q.z = ratio_fx(a10 - a01, den);
      end
      CASE_X: begin
        r = root_fx(a00 - a11 - a22 + one); den = 2 * r;
        q.w = ratio_fx(a21 - a12, den);
        q.x = q_t'(clip16(r >>> 1));
        q.y = ratio_fx(a01 + a10, den);
        q.z = ratio_fx(a02 + a20, den);
      end
      CASE_Y: begin
        r = root_fx(a11 - a22 - a00 + one); den = 2 * r;
        q.w = ratio_fx(a02 - a20, den);
        q.x = ratio_fx(a10 + a01, den);
        q.y = q_t'(clip16(r >>> 1));
        q.z = ratio_fx(a12 + a21, den);
      end
      default: begin
        r = root_fx(a22 - a00 - a11 + one); den = 2 * r;
        q.w = ratio_fx(a10 - a01, den);
        q.x = ratio_fx(a20 + a02, den);
        q.y = ratio_fx(a21 + a12, den);
        q.z = q_t'(clip16(r >>> 1));
      end
    endcase
    return q;
  endfunction

  function automatic matrix_t diag_mat(q_t d0, q_t d1, q_t d2, q_t off);
    matrix_t mt;
    foreach (mt.m[i]) mt.m[i] = off;
    mt.m[0] = d0; mt.m[4] = d1; mt.m[8] = d2;
    return mt;
  endfunction

  function automatic matrix_t fill_mat(q_t v);
    matrix_t mt;
    foreach (mt.m[i]) mt.m[i] = v;
    return mt;
  endfunction

  // random matrix: near-rotation shapes, small values, or full noise
  function automatic matrix_t rand_mat();
    matrix_t mt;
    int      k;
    k = $urandom_range(0, 9);
    foreach (mt.m[i]) begin
      if (k < 3) mt.m[i] = q_t'($urandom);
      else if (k < 6) mt.m[i] = q_t'($signed($urandom_range(0, 32768)) - 16384);
      else mt.m[i] = q_t'($signed($urandom_range(0, 2000)) - 1000);
    end
    // bias the diagonal so every branch shows up often
    if (k >= 3) begin
      case ($urandom_range(0, 3))
        0: mt.m[0] = q_t'(16384 - $urandom_range(0, 800));
        1: mt.m[4] = q_t'(16384 - $urandom_range(0, 800));
        2: mt.m[8] = q_t'(16384 - $urandom_range(0, 800));
        default: ;
      endcase
    end
    return mt;
  endfunction

  task automatic report_mismatch(string fld, int got, int want);
    $display("mismatch %s: got %0d expected %0d", fld, got, want);
    n_errors++;
  endtask

  // driver: push the next pending beat, hold it while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_quats.push_back(
          matrix_to_quat('{m: '{in_m00, in_m01, in_m02, in_m10, in_m11, in_m12,
                                in_m20, in_m21, in_m22}}));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || hold_input || pending_mats.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          matrix_t mt;
          mt = pending_mats.pop_front();
          in_valid <= 1'b1;
          {in_m00, in_m01, in_m02} <= {mt.m[0], mt.m[1], mt.m[2]};
          {in_m10, in_m11, in_m12} <= {mt.m[3], mt.m[4], mt.m[5]};
          {in_m20, in_m21, in_m22} <= {mt.m[6], mt.m[7], mt.m[8]};
          in_gap <= pick_gap();
        end
      end
    end
  end

  // monitor: compare each result beat, then randomize the stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected beat, quat_w", out_quat_w, 0);
        end else begin
          quat_t q;
          q = expected_quats.pop_front();
          if (out_quat_w !== q.w) report_mismatch("quat_w", out_quat_w, q.w);
          if (out_quat_x !== q.x) report_mismatch("quat_x", out_quat_x, q.x);
          if (out_quat_y !== q.y) report_mismatch("quat_y", out_quat_y, q.y);
          if (out_quat_z !== q.z) report_mismatch("quat_z", out_quat_z, q.z);
          if (out_case_taken !== q.which)
            report_mismatch("case_taken", out_case_taken, q.which);
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // directed: identity, each axis case, ties, extremes, zero divisors
    pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
    pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
    pending_mats.push_back(diag_mat(-8192, -8192, -8192, 100));
    pending_mats.push_back(diag_mat(-20000, -20000, -3000, 0));
    pending_mats.push_back(diag_mat(-5000, -5000, -9000, 0));
    pending_mats.push_back(diag_mat(-9000, -5000, -5000, 0));
    pending_mats.push_back(fill_mat(q_t'(16'h7FFF)));
    pending_mats.push_back(fill_mat(q_t'(16'h8000)));
    pending_mats.push_back(fill_mat(q_t'(16'hFFFF)));
    pending_mats.push_back(fill_mat(q_t'(0)));
    pending_mats.push_back(diag_mat(q_t'(16'h8000), q_t'(16'h7FFF), q_t'(16'h8000),
                                    q_t'(16'h7FFF)));
    pending_mats.push_back(diag_mat(q_t'(16'h8000), q_t'(16'h8000), q_t'(16'h7FFF),
                                    q_t'(16'h8000)));
    pending_mats.push_back(diag_mat(-16384, 0, 0, 16384));
    pending_mats.push_back(diag_mat(-30000, 10000, -30000, -12345));
    pending_mats.push_back(diag_mat(1, -1, 1, 32767));
    pending_mats.push_back(diag_mat(-10000, -10000, -10000, q_t'(16'h8000)));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // pause the sender until everything in flight has drained
    wait (pending_mats.size() == 0);
    hold_input = 1'b1;
    wait (expected_quats.size() == 0 && !in_valid);
    repeat (25) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      pending_mats.push_back(rand_mat());
      if (i == N_RANDOM / 2) begin
        // another drain pause in the middle of the random run
        hold_input = 1'b0;
        wait (pending_mats.size() == 0);
        hold_input = 1'b1;
        wait (expected_quats.size() == 0 && !in_valid);
      end
    end
    hold_input = 1'b0;
    wait (pending_mats.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (expected_quats.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rmq_pkg.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
tb/tb_rotation_matrix_to_quaternion_top.sv
